/* hdl/iuhb_pkg.sv */
// Package for the IPv4/UDP header builder: item, entry and config types,
// header constants and the ones'-complement adder. No dependencies.
`timescale 1ns / 1ps

package iuhb_pkg;

	typedef logic [11:0] off_t;
	typedef logic [15:0] len_t;
	typedef logic [4:0]  idx_t;
	typedef logic [1:0]  cfg_addr_t;

	typedef enum cfg_addr_t {
		CFG_SRC_ADDR = 2'd0,
		CFG_DST_ADDR = 2'd1,
		CFG_SRC_PORT = 2'd2,
		CFG_DST_PORT = 2'd3
	} cfg_reg_e;

	localparam int   Q_DEPTH = 2;
	localparam int   Q_PTR_W = 1;
	localparam int   Q_CNT_W = 2;

	localparam len_t HDR_LEN  = 16'd28;
	localparam len_t UDP_HLEN = 16'd8;
	localparam idx_t LAST_HDR_IDX = 5'd27;

	localparam logic [15:0] IP_VER_IHL_TOS = 16'h4500;
	localparam logic [15:0] IP_IDENT       = 16'h0002;
	localparam logic [15:0] IP_FLAGS_DF    = 16'h4000;
	localparam logic [15:0] IP_TTL_PROTO   = 16'h4011;
	localparam logic [15:0] PROTO_UDP      = 16'h0011;
	localparam logic [15:0] CSUM_ALL_ONES  = 16'hFFFF;

	typedef struct packed {
		logic [31:0] ip_src;
		logic [31:0] ip_dst;
		logic [15:0] src_port;
		logic [15:0] dst_port;
	} cfg_t;

	typedef struct packed {
		logic        has_payload;
		logic        has_header;
		logic [7:0]  data;
		off_t        offset;
		len_t        length;
		logic [31:0] sum;
		logic [15:0] pad;
	} entry_t;

	typedef struct packed {
		logic valid;
		logic full;
	} q_stat_t;

	typedef struct packed {
		logic hdr_active;
		idx_t hdr_idx;
	} bk_stat_t;

	function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = 17'(a) + 17'(b);
		return 16'(s[15:0] + 16'(s[16]));
	endfunction

endpackage

/* hdl/iuhb_if.sv */
// Valid/ready channel interfaces for payload bytes in and packet bytes out.
// Depends on nothing.
`timescale 1ns / 1ps

interface iuhb_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic       last_byte;

	modport source (output valid, output payload_byte, output last_byte, input ready);
	modport sink   (input valid, input payload_byte, input last_byte, output ready);
endinterface

interface iuhb_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  byte_value;
	logic [11:0] byte_offset;
	logic        last_of_run;

	modport source (output valid, output byte_value, output byte_offset, output last_of_run,
		input ready);
	modport sink   (input valid, input byte_value, input byte_offset, input last_of_run,
		output ready);
endinterface

/* hdl/iuhb_front.sv */
// Front end: accepts payload bytes, keeps count and running payload sum,
// classifies each item and pushes a work entry. Uses iuhb_pkg, iuhb_if.
`timescale 1ns / 1ps

module iuhb_front #(
	parameter int MAX_PAYLOAD = 2048
) (
	input  logic             clk,
	input  logic             arst_n,
	iuhb_in_if.sink          in_ch,
	input  logic             q_full,
	output logic             push,
	output iuhb_pkg::entry_t entry
);

	localparam int CW = $clog2(MAX_PAYLOAD + 1);

	logic [CW-1:0] count_q;
	logic [31:0]   sum_q;
	logic [7:0]    held_q;

	logic          accept;
	logic          take;
	logic          odd;
	logic [CW-1:0] cnt_n;
	logic [31:0]   sum_add;
	logic [31:0]   sum_fold;
	logic [31:0]   sum_n;
	logic [7:0]    held_n;

	assign in_ch.ready = !q_full;
	assign accept      = in_ch.valid && !q_full;
	assign take        = count_q < CW'(MAX_PAYLOAD);
	assign odd         = count_q[0];

	always_comb begin
		sum_add  = sum_q + 32'({held_q, in_ch.payload_byte});
		sum_fold = sum_add[31] ? 32'(sum_add[15:0]) + 32'(sum_add[31:16]) : sum_add;
		sum_n    = (take && odd) ? sum_fold : sum_q;
		held_n   = (take && !odd) ? in_ch.payload_byte : held_q;
		cnt_n    = take ? count_q + CW'(1) : count_q;
	end

	assign push = accept && (take || in_ch.last_byte);

	always_comb begin
		entry.has_payload = take;
		entry.has_header  = in_ch.last_byte;
		entry.data        = in_ch.payload_byte;
		entry.offset      = iuhb_pkg::off_t'(iuhb_pkg::len_t'(count_q) + iuhb_pkg::HDR_LEN);
		entry.length      = iuhb_pkg::len_t'(cnt_n);
		entry.sum         = sum_n;
		entry.pad         = cnt_n[0] ? {held_n, 8'h00} : 16'h0000;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			held_q  <= '0;
		end else if (accept) begin
			if (in_ch.last_byte) begin
				count_q <= '0;
				sum_q   <= '0;
				held_q  <= '0;
			end else begin
				count_q <= cnt_n;
				sum_q   <= sum_n;
				held_q  <= held_n;
			end
		end
	end

endmodule

/* hdl/iuhb_queue.sv */
// Short work queue between front end and header sequencer.
// Uses iuhb_pkg.
`timescale 1ns / 1ps

module iuhb_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  iuhb_pkg::entry_t  wr_entry,
	input  logic              pop,
	output iuhb_pkg::entry_t  head,
	output iuhb_pkg::q_stat_t stat
);

	iuhb_pkg::entry_t                     mem_q [iuhb_pkg::Q_DEPTH];
	logic [iuhb_pkg::Q_PTR_W-1:0]         wr_ptr_q;
	logic [iuhb_pkg::Q_PTR_W-1:0]         rd_ptr_q;
	logic [iuhb_pkg::Q_CNT_W-1:0]         cnt_q;
	logic                                 do_push;
	logic                                 do_pop;

	assign stat.valid = cnt_q != '0;
	assign stat.full  = cnt_q == iuhb_pkg::Q_CNT_W'(iuhb_pkg::Q_DEPTH);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && stat.valid;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + iuhb_pkg::Q_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + iuhb_pkg::Q_PTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + iuhb_pkg::Q_CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - iuhb_pkg::Q_CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* hdl/iuhb_back.sv */
// Back end: emits payload bytes and runs the 28-byte header burst, summing
// both checksums one term per step. Uses iuhb_pkg, iuhb_if.
`timescale 1ns / 1ps

module iuhb_back (
	input  logic               clk,
	input  logic               arst_n,
	input  iuhb_pkg::cfg_t     cfg,
	input  logic               q_valid,
	input  iuhb_pkg::entry_t   head,
	output logic               pop,
	output iuhb_pkg::bk_stat_t stat,
	iuhb_out_if.source         out_ch
);

	logic              out_valid_q;
	logic [7:0]        byte_q;
	iuhb_pkg::off_t    off_q;
	logic              last_q;
	logic              hdr_act_q;
	iuhb_pkg::idx_t    idx_q;
	logic [15:0]       acc_ip_q;
	logic [15:0]       acc_ud_q;

	logic              adv;
	logic              step;
	logic              hdr_end;
	iuhb_pkg::len_t    tot_len;
	iuhb_pkg::len_t    udp_len;
	logic [15:0]       ip_csum;
	logic [15:0]       ud_raw;
	logic [15:0]       ud_csum;
	logic [15:0]       ip_term;
	logic [15:0]       ud_term;
	logic [7:0]        hdr_byte;

	assign adv     = !out_valid_q || out_ch.ready;
	assign step    = adv && q_valid;
	assign hdr_end = idx_q == iuhb_pkg::LAST_HDR_IDX;
	assign pop     = step && (hdr_act_q ? hdr_end : !head.has_header);

	assign stat.hdr_active = hdr_act_q;
	assign stat.hdr_idx    = idx_q;

	assign tot_len = head.length + iuhb_pkg::HDR_LEN;
	assign udp_len = head.length + iuhb_pkg::UDP_HLEN;
	assign ip_csum = ~acc_ip_q;
	assign ud_raw  = ~acc_ud_q;
	assign ud_csum = (ud_raw == 16'h0000) ? iuhb_pkg::CSUM_ALL_ONES : ud_raw;

	always_comb begin
		case (idx_q)
			5'd0:    ip_term = iuhb_pkg::IP_VER_IHL_TOS;
			5'd1:    ip_term = tot_len;
			5'd2:    ip_term = iuhb_pkg::IP_IDENT;
			5'd3:    ip_term = iuhb_pkg::IP_FLAGS_DF;
			5'd4:    ip_term = iuhb_pkg::IP_TTL_PROTO;
			5'd5:    ip_term = cfg.ip_src[31:16];
			5'd6:    ip_term = cfg.ip_src[15:0];
			5'd7:    ip_term = cfg.ip_dst[31:16];
			5'd8:    ip_term = cfg.ip_dst[15:0];
			default: ip_term = 16'h0000;
		endcase
		case (idx_q)
			5'd0:    ud_term = head.sum[31:16];
			5'd1:    ud_term = head.sum[15:0];
			5'd2:    ud_term = head.pad;
			5'd3:    ud_term = cfg.ip_src[31:16];
			5'd4:    ud_term = cfg.ip_src[15:0];
			5'd5:    ud_term = cfg.ip_dst[31:16];
			5'd6:    ud_term = cfg.ip_dst[15:0];
			5'd7:    ud_term = iuhb_pkg::PROTO_UDP;
			5'd8:    ud_term = udp_len;
			5'd9:    ud_term = cfg.src_port;
			5'd10:   ud_term = cfg.dst_port;
			5'd11:   ud_term = udp_len;
			default: ud_term = 16'h0000;
		endcase
		case (idx_q)
			5'd0:    hdr_byte = iuhb_pkg::IP_VER_IHL_TOS[15:8];
			5'd1:    hdr_byte = iuhb_pkg::IP_VER_IHL_TOS[7:0];
			5'd2:    hdr_byte = tot_len[15:8];
			5'd3:    hdr_byte = tot_len[7:0];
			5'd4:    hdr_byte = iuhb_pkg::IP_IDENT[15:8];
			5'd5:    hdr_byte = iuhb_pkg::IP_IDENT[7:0];
			5'd6:    hdr_byte = iuhb_pkg::IP_FLAGS_DF[15:8];
			5'd7:    hdr_byte = iuhb_pkg::IP_FLAGS_DF[7:0];
			5'd8:    hdr_byte = iuhb_pkg::IP_TTL_PROTO[15:8];
			5'd9:    hdr_byte = iuhb_pkg::IP_TTL_PROTO[7:0];
			5'd10:   hdr_byte = ip_csum[15:8];
			5'd11:   hdr_byte = ip_csum[7:0];
			5'd12:   hdr_byte = cfg.ip_src[31:24];
			5'd13:   hdr_byte = cfg.ip_src[23:16];
			5'd14:   hdr_byte = cfg.ip_src[15:8];
			5'd15:   hdr_byte = cfg.ip_src[7:0];
			5'd16:   hdr_byte = cfg.ip_dst[31:24];
			5'd17:   hdr_byte = cfg.ip_dst[23:16];
			5'd18:   hdr_byte = cfg.ip_dst[15:8];
			5'd19:   hdr_byte = cfg.ip_dst[7:0];
			5'd20:   hdr_byte = cfg.src_port[15:8];
			5'd21:   hdr_byte = cfg.src_port[7:0];
			5'd22:   hdr_byte = cfg.dst_port[15:8];
			5'd23:   hdr_byte = cfg.dst_port[7:0];
			5'd24:   hdr_byte = udp_len[15:8];
			5'd25:   hdr_byte = udp_len[7:0];
			5'd26:   hdr_byte = ud_csum[15:8];
			5'd27:   hdr_byte = ud_csum[7:0];
			default: hdr_byte = 8'h00;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			byte_q      <= '0;
			off_q       <= '0;
			last_q      <= 1'b0;
			hdr_act_q   <= 1'b0;
			idx_q       <= '0;
			acc_ip_q    <= '0;
			acc_ud_q    <= '0;
		end else if (adv) begin
			out_valid_q <= step && (hdr_act_q || head.has_payload);
			if (step) begin
				if (hdr_act_q) begin
					byte_q   <= hdr_byte;
					off_q    <= iuhb_pkg::off_t'(idx_q);
					last_q   <= hdr_end;
					acc_ip_q <= iuhb_pkg::ones_add(acc_ip_q, ip_term);
					acc_ud_q <= iuhb_pkg::ones_add(acc_ud_q, ud_term);
					idx_q    <= idx_q + iuhb_pkg::idx_t'(1);
					if (hdr_end) begin
						hdr_act_q <= 1'b0;
					end
				end else begin
					byte_q <= head.data;
					off_q  <= head.offset;
					last_q <= !head.has_header;
					if (head.has_header) begin
						hdr_act_q <= 1'b1;
						idx_q     <= '0;
						acc_ip_q  <= '0;
						acc_ud_q  <= '0;
					end
				end
			end
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.byte_value  = byte_q;
	assign out_ch.byte_offset = off_q;
	assign out_ch.last_of_run = last_q;

endmodule

/* hdl/ipv4_udp_header_builder.sv */
// Channel   Dir  Payload                                     Handshake
// in_ch     in   payload_byte[7:0], last_byte                valid/ready
// out_ch    out  byte_value[7:0], byte_offset[11:0], last_of_run  valid/ready
// cfg       in   cfg_wr_en, cfg_index[1:0], cfg_data[31:0]  write on enable
//
// One payload byte per cycle in and out while nothing stalls, through the
// queue and the output register. A last byte adds a 28-byte header burst
// from the back-end sequencer, which also sums both checksums one term per
// cycle unless the output stalls; the 2-entry queue lets the front take one
// byte of the next datagram during the burst. Reset clears config, counts and
// sums. Output stalls hold the back end; with the queue full, also the input.
// Top level of the IPv4/UDP header builder; uses iuhb_pkg, iuhb_if and the
// iuhb_front, iuhb_queue and iuhb_back modules.
`timescale 1ns / 1ps

module ipv4_udp_header_builder #(
	parameter int MAX_PAYLOAD = 2048
) (
	input  logic                clk,
	input  logic                arst_n,
	iuhb_in_if.sink             in_ch,
	iuhb_out_if.source          out_ch,
	input  logic                cfg_wr_en,
	input  iuhb_pkg::cfg_addr_t cfg_index,
	input  logic [31:0]         cfg_data
);

	iuhb_pkg::cfg_t     cfg_q;
	iuhb_pkg::entry_t   wr_entry;
	iuhb_pkg::entry_t   head;
	iuhb_pkg::q_stat_t  q_stat;
	iuhb_pkg::bk_stat_t bk_stat;
	logic               q_push;
	logic               q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				iuhb_pkg::CFG_SRC_ADDR: cfg_q.ip_src   <= cfg_data;
				iuhb_pkg::CFG_DST_ADDR: cfg_q.ip_dst   <= cfg_data;
				iuhb_pkg::CFG_SRC_PORT: cfg_q.src_port <= cfg_data[15:0];
				iuhb_pkg::CFG_DST_PORT: cfg_q.dst_port <= cfg_data[15:0];
				default:                cfg_q <= cfg_q;
			endcase
		end
	end

	iuhb_front #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.q_full (q_stat.full),
		.push   (q_push),
		.entry  (wr_entry)
	);

	iuhb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (wr_entry),
		.pop      (q_pop),
		.head     (head),
		.stat     (q_stat)
	);

	iuhb_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_valid (q_stat.valid),
		.head    (head),
		.pop     (q_pop),
		.stat    (bk_stat),
		.out_ch  (out_ch)
	);

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_stat.valid)
		else $error("queue popped while empty");

	a_full_after_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(q_stat.full) |-> $past(q_push))
		else $error("queue became full without a push");

	a_burst_length: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(bk_stat.hdr_active) |-> $past(bk_stat.hdr_idx) == iuhb_pkg::LAST_HDR_IDX)
		else $error("header burst ended early");

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("push into a full queue");

endmodule

/* sim/ipv4_udp_header_builder_tb.sv */
// Testbench for ipv4_udp_header_builder: streams payload bytes with random gaps,
// predicts every packet byte and both checksums, and compares item by item.
// Depends on iuhb_pkg, iuhb_if and the RTL of the header builder.
`timescale 1ns / 1ps

module ipv4_udp_header_builder_tb;

	localparam int MAX_BYTES   = 2048;
	localparam int HDR_BYTES   = 28;
	localparam int IP_BYTES    = 20;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_WAIT  = 40;

	localparam logic [7:0]  VER_IHL   = 8'h45;
	localparam logic [15:0] IDENT     = 16'h0002;
	localparam logic [15:0] FLAGS_DF  = 16'h4000;
	localparam logic [7:0]  TTL       = 8'd64;
	localparam logic [7:0]  PROTO     = 8'd17;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} pay_item_t;

	typedef struct {
		logic [7:0]  value;
		logic [11:0] offset;
		logic        last;
	} pkt_byte_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	iuhb_pkg::cfg_addr_t cfg_index;
	logic [31:0] cfg_data;

	iuhb_in_if  in_ch();
	iuhb_out_if out_ch();

	ipv4_udp_header_builder u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	pay_item_t pending_bytes[$];
	pkt_byte_t exp_bytes[$];

	iuhb_pkg::cfg_t cfg_shadow;
	int          pay_cnt;
	logic [31:0] pay_sum;
	logic [7:0]  held_hi;

	int        err_count;
	int        stall_cycles;
	logic      in_took;
	logic      calm;
	int        in_hold;
	int        out_hold;
	pay_item_t drv_item;

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = iuhb_pkg::CFG_SRC_ADDR;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.payload_byte = '0;
		in_ch.last_byte = 1'b0;
		out_ch.ready = 1'b0;
		cfg_shadow = '0;
		pay_cnt = 0;
		pay_sum = '0;
		held_hi = '0;
		err_count = 0;
		stall_cycles = 0;
		in_took = 1'b0;
		calm = 1'b0;
		in_hold = 0;
		out_hold = 0;
	end

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm)
			return 0;
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [15:0] fold_csum(input logic [63:0] s);
		while (s[63:16] != '0)
			s = {48'b0, s[15:0]} + (s >> 16);
		return s[15:0];
	endfunction

	task automatic push_byte(input logic [7:0] v, input int off, input logic lst);
		pkt_byte_t e;
		e.value = v;
		e.offset = 12'(off);
		e.last = lst;
		exp_bytes.push_back(e);
	endtask

	// header bytes are appended after the payload byte of the same item
	task automatic predict_item(input logic [7:0] b, input logic lst);
		logic [7:0]  hdr[HDR_BYTES];
		logic [63:0] s;
		logic [15:0] tot_len;
		logic [15:0] udp_len;
		logic [15:0] c;
		int i;
		if (pay_cnt < MAX_BYTES) begin
			if (pay_cnt % 2 == 0) begin
				held_hi = b;
			end else begin
				pay_sum = pay_sum + {16'b0, held_hi, b};
				if (pay_sum[31])
					pay_sum = {16'b0, pay_sum[15:0]} + (pay_sum >> 16);
			end
			push_byte(b, HDR_BYTES + pay_cnt, !lst);
			pay_cnt++;
		end
		if (lst) begin
			tot_len = 16'(HDR_BYTES + pay_cnt);
			udp_len = 16'(8 + pay_cnt);
			for (i = 0; i < HDR_BYTES; i++)
				hdr[i] = 8'h00;
			hdr[0] = VER_IHL;
			{hdr[2], hdr[3]} = tot_len;
			{hdr[4], hdr[5]} = IDENT;
			{hdr[6], hdr[7]} = FLAGS_DF;
			hdr[8] = TTL;
			hdr[9] = PROTO;
			{hdr[12], hdr[13], hdr[14], hdr[15]} = cfg_shadow.ip_src;
			{hdr[16], hdr[17], hdr[18], hdr[19]} = cfg_shadow.ip_dst;
			s = '0;
			for (i = 0; i < IP_BYTES; i += 2)
				s += {48'b0, hdr[i], hdr[i + 1]};
			{hdr[10], hdr[11]} = ~fold_csum(s);
			{hdr[20], hdr[21]} = cfg_shadow.src_port;
			{hdr[22], hdr[23]} = cfg_shadow.dst_port;
			{hdr[24], hdr[25]} = udp_len;
			s = {32'b0, pay_sum};
			if (pay_cnt % 2 == 1)
				s += {48'b0, held_hi, 8'h00};
			s += {48'b0, cfg_shadow.ip_src[31:16]};
			s += {48'b0, cfg_shadow.ip_src[15:0]};
			s += {48'b0, cfg_shadow.ip_dst[31:16]};
			s += {48'b0, cfg_shadow.ip_dst[15:0]};
			s += {56'b0, PROTO};
			s += {48'b0, udp_len};
			for (i = IP_BYTES; i < HDR_BYTES; i += 2)
				s += {48'b0, hdr[i], hdr[i + 1]};
			c = ~fold_csum(s);
			if (c == 16'h0000)
				c = 16'hFFFF;
			{hdr[26], hdr[27]} = c;
			for (i = 0; i < HDR_BYTES; i++)
				push_byte(hdr[i], i, i == HDR_BYTES - 1);
			pay_cnt = 0;
			pay_sum = '0;
			held_hi = '0;
		end
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		if (err_count < 50)
			$display("%0t ns: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
		err_count++;
	endtask

	// predict on input items, then check output items against the oldest expectation
	always @(posedge clk) begin
		pkt_byte_t e;
		in_took <= in_ch.valid && in_ch.ready;
		if (in_ch.valid && in_ch.ready)
			predict_item(in_ch.payload_byte, in_ch.last_byte);
		if (out_ch.valid && out_ch.ready) begin
			if (exp_bytes.size() == 0) begin
				report_mismatch("unexpected item", out_ch.byte_offset, 0);
			end else begin
				e = exp_bytes.pop_front();
				if (out_ch.byte_value !== e.value)
					report_mismatch("byte_value", out_ch.byte_value, e.value);
				if (out_ch.byte_offset !== e.offset)
					report_mismatch("byte_offset", out_ch.byte_offset, e.offset);
				if (out_ch.last_of_run !== e.last)
					report_mismatch("last_of_run", out_ch.last_of_run, e.last);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (!in_ch.valid || in_took) begin
			if (in_hold > 0) begin
				in_ch.valid <= 1'b0;
				in_hold--;
			end else if (pending_bytes.size() > 0) begin
				drv_item = pending_bytes.pop_front();
				in_ch.valid <= 1'b1;
				in_ch.payload_byte <= drv_item.data;
				in_ch.last_byte <= drv_item.last;
				in_hold = pick_gap();
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (out_hold > 0) begin
			out_ch.ready <= 1'b0;
			out_hold--;
		end else begin
			out_ch.ready <= 1'b1;
			out_hold = pick_gap();
		end
	end

	task automatic write_cfg(input logic [31:0] sa, input logic [31:0] da,
		input logic [15:0] sp, input logic [15:0] dp);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = iuhb_pkg::CFG_SRC_ADDR;
		cfg_data = sa;
		@(negedge clk);
		cfg_index = iuhb_pkg::CFG_DST_ADDR;
		cfg_data = da;
		@(negedge clk);
		cfg_index = iuhb_pkg::CFG_SRC_PORT;
		cfg_data = {16'b0, sp};
		@(negedge clk);
		cfg_index = iuhb_pkg::CFG_DST_PORT;
		cfg_data = {16'b0, dp};
		@(negedge clk);
		cfg_wr_en = 1'b0;
		cfg_shadow.ip_src = sa;
		cfg_shadow.ip_dst = da;
		cfg_shadow.src_port = sp;
		cfg_shadow.dst_port = dp;
	endtask

	task automatic add_byte(input logic [7:0] v, input logic lst);
		pay_item_t it;
		it.data = v;
		it.last = lst;
		pending_bytes.push_back(it);
	endtask

	task automatic add_datagram(input int len);
		int i;
		for (i = 0; i < len; i++)
			add_byte(8'($urandom), i == len - 1);
	endtask

	// hold until every item is taken and every expected byte is out
	task automatic drain();
		while (pending_bytes.size() != 0 || in_ch.valid || exp_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_word();
		int r;
		r = $urandom_range(0, 5);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return $urandom;
	endfunction

	initial begin
		int ph;
		int nbytes;
		int len;
		int r;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// zero config: UDP checksum that computes to zero, odd and even sizes
		write_cfg(32'h0, 32'h0, 16'h0, 16'h0);
		add_byte(8'hFF, 1'b0);
		add_byte(8'hDA, 1'b1);
		add_byte(8'h00, 1'b1);
		add_byte(8'hFF, 1'b1);
		add_byte(8'h00, 1'b0);
		add_byte(8'hFF, 1'b0);
		add_byte(8'h80, 1'b0);
		add_byte(8'h01, 1'b0);
		add_byte(8'h7F, 1'b1);
		drain();

		calm = 1'b1;
		write_cfg(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
		add_byte(8'hFF, 1'b0);
		add_byte(8'hFF, 1'b0);
		add_byte(8'hFF, 1'b1);
		add_byte(8'h00, 1'b0);
		add_byte(8'h00, 1'b1);
		add_byte(8'hA5, 1'b1);
		drain();

		for (ph = 0; ph < 7; ph++) begin
			calm = ($urandom_range(0, 3) == 0);
			write_cfg(pick_word(), pick_word(), 16'(pick_word()), 16'(pick_word()));
			nbytes = 0;
			while (nbytes < 60) begin
				r = $urandom_range(0, 99);
				if (r < 70)
					len = $urandom_range(1, 8);
				else if (r < 95)
					len = $urandom_range(9, 64);
				else
					len = $urandom_range(65, 300);
				add_datagram(len);
				nbytes += len;
			end
			drain();
		end

		if (err_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

/* ipv4_udp_header_builder.f */
hdl/iuhb_pkg.sv
hdl/iuhb_if.sv
hdl/iuhb_front.sv
hdl/iuhb_queue.sv
hdl/iuhb_back.sv
hdl/ipv4_udp_header_builder.sv
sim/ipv4_udp_header_builder_tb.sv
